[rtl/dlpe_pkg.sv]
// Shared constants of the DHCP lease pool engine: command and reply codes, register map.
package dlpe_pkg;

   localparam int MAC_W   = 48;
   localparam int IP_W    = 32;
   localparam int LEASE_W = 31;
   localparam int CMD_W   = 2;
   localparam int KIND_W  = 2;
   localparam int LIDX_W  = 4;
   localparam int EIU_W   = 5;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // command codes of an input word
   localparam logic [CMD_W-1:0] CMD_DISCOVER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd2;

   // reply kinds of a result word
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OFFER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_ENTRIES_IN_USE = 2'd0;
   localparam logic [1:0] REG_SERVER_ADDR    = 2'd1;
   localparam logic [1:0] REG_DNS_IP         = 2'd2;

endpackage

[rtl/dlpe_ifs.sv]
// Handshake interfaces for the request and response channels.
interface dlpe_req_if;
   logic                              valid;
   logic                              ready;
   logic [dlpe_pkg::CMD_W-1:0]        command;
   logic [dlpe_pkg::MAC_W-1:0]        client_mac;
   logic [dlpe_pkg::IP_W-1:0]         requested_ip;
   logic                              requested_present;
   logic [dlpe_pkg::LIDX_W-1:0]       load_index;
   logic [dlpe_pkg::IP_W-1:0]         load_ip;
   logic [dlpe_pkg::IP_W-1:0]         load_subnet;
   logic [dlpe_pkg::LEASE_W-1:0]      load_lease;

   modport source (output valid, command, client_mac, requested_ip, requested_present,
                   load_index, load_ip, load_subnet, load_lease,
                   input ready);
   modport sink   (input valid, command, client_mac, requested_ip, requested_present,
                   load_index, load_ip, load_subnet, load_lease,
                   output ready);
endinterface

interface dlpe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dlpe_pkg::KIND_W-1:0]       reply_kind;
   logic [dlpe_pkg::IP_W-1:0]         your_ip;
   logic [dlpe_pkg::IP_W-1:0]         subnet_mask;
   logic [dlpe_pkg::LEASE_W-1:0]      lease_seconds;
   logic [dlpe_pkg::IP_W-1:0]         server_id;
   logic [dlpe_pkg::IP_W-1:0]         dns_server;

   modport source (output valid, reply_kind, your_ip, subnet_mask, lease_seconds,
                   server_id, dns_server,
                   input ready);
   modport sink   (input valid, reply_kind, your_ip, subnet_mask, lease_seconds,
                   server_id, dns_server,
                   output ready);
endinterface

[rtl/dhcp_lease_pool_engine.sv]
// DHCP lease pool engine: sequential pool search with one shared comparator.
//
// Usage
//  - req_bus carries one command word: discover, request or pool entry load.
//  - rsp_bus returns exactly one result word per command; reply kind none
//    comes with every field zero.
//  - APB-style port (psel/penable/pwrite, 4-bit paddr, 32-bit data) holds
//    entries_in_use at 0x0, the server address at 0x4 and dns_ip at 0x8;
//    pready is tied high. Write only while the engine is idle.
// Timing
//  - One word in flight; req_bus.ready is high only while idle.
//  - Each searched entry takes a registered read, then a compare in the
//    shared comparator; the search covers min(entries_in_use, POOL_ENTRIES).
//  - Discover scans the owners once. Request scans the owners, frees the
//    client's old entry, then scans the IP addresses. Load and no-reply
//    words skip the search.
// Reset
//  - Owner valid bits clear on reset; an invalid entry reads as vacant.
//  - No clearing sweep, so the engine is ready straight after reset.
// Back-pressure
//  - The result sits in an output register; the next word is accepted while
//    it waits, and its result is held back until rsp_bus.ready frees it.
module dhcp_lease_pool_engine #(
   parameter int POOL_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   dlpe_req_if.sink                      req_bus,
   dlpe_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dlpe_pkg::CSR_AW-1:0]   paddr,
   input  logic [dlpe_pkg::CSR_DW-1:0]   pwdata,
   output logic [dlpe_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
   localparam int MAC_W = dlpe_pkg::MAC_W;
   localparam int IP_W  = dlpe_pkg::IP_W;
   localparam int LS_W  = dlpe_pkg::LEASE_W;

   // sequencer: issue read, compare, decide after a scan, fetch chosen entry, reply
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,
      ST_CMP  = 6'b000100,
      ST_END  = 6'b001000,
      ST_LOOK = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

   // ---------------- configuration registers ----------------
   logic [dlpe_pkg::EIU_W-1:0] entries_ff, entries_in;
   logic [IP_W-1:0]            server_ff, server_in;
   logic [IP_W-1:0]            dns_ff, dns_in;
   logic                       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      entries_in = entries_ff;
      server_in  = server_ff;
      dns_in     = dns_ff;
      if (csr_wr) begin
         unique case (paddr[3:2])
            dlpe_pkg::REG_ENTRIES_IN_USE: entries_in = pwdata[dlpe_pkg::EIU_W-1:0];
            dlpe_pkg::REG_SERVER_ADDR:    server_in  = pwdata;
            dlpe_pkg::REG_DNS_IP:         dns_in     = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         dlpe_pkg::REG_ENTRIES_IN_USE:
            prdata = {{(dlpe_pkg::CSR_DW-dlpe_pkg::EIU_W){1'b0}}, entries_ff};
         dlpe_pkg::REG_SERVER_ADDR: prdata = server_ff;
         dlpe_pkg::REG_DNS_IP:      prdata = dns_ff;
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         server_ff  <= '0;
         dns_ff     <= '0;
      end else begin
         entries_ff <= entries_in;
         server_ff  <= server_in;
         dns_ff     <= dns_in;
      end
   end

   // search length, clamped to the pool size
   logic [CNT_W-1:0] n_len;
   assign n_len = (32'(entries_ff) > POOL_ENTRIES) ? CNT_W'(POOL_ENTRIES)
                                                   : CNT_W'(entries_ff);

   // ---------------- pool stores ----------------
   logic [MAC_W-1:0]        own_mem [POOL_ENTRIES];
   logic [POOL_ENTRIES-1:0] own_vld_ff;
   logic [IP_W-1:0]         ip_mem  [POOL_ENTRIES];
   logic [IP_W-1:0]         sub_mem [POOL_ENTRIES];
   logic [LS_W-1:0]         lse_mem [POOL_ENTRIES];

   logic [MAC_W-1:0]  own_rd_ff;
   logic              vld_rd_ff;
   logic [IP_W-1:0]   ip_rd_ff;
   logic [IP_W-1:0]   sub_rd_ff;
   logic [LS_W-1:0]   lse_rd_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              own_we;
   logic [IDX_W-1:0]  own_wa;
   logic [MAC_W-1:0]  own_wd;
   logic              load_we;
   logic [IDX_W-1:0]  load_wa;

   assign load_wa = IDX_W'(req_bus.load_index);

   always_ff @(posedge clock) begin
      if (own_we) own_mem[own_wa] <= own_wd;
      if (rd_en)  own_rd_ff <= own_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_vld_ff <= '0;
      end else if (own_we) begin
         own_vld_ff[own_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) vld_rd_ff <= own_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         ip_mem[load_wa]  <= req_bus.load_ip;
         sub_mem[load_wa] <= req_bus.load_subnet;
         lse_mem[load_wa] <= req_bus.load_lease;
      end
      if (rd_en) begin
         ip_rd_ff  <= ip_mem[rd_addr];
         sub_rd_ff <= sub_mem[rd_addr];
         lse_rd_ff <= lse_mem[rd_addr];
      end
   end

   // never-written owner slot reads as vacant
   logic [MAC_W-1:0] owner_eff;
   assign owner_eff = vld_rd_ff ? own_rd_ff : '0;

   // ---------------- sequencer state ----------------
   state_type                   state_ff, state_in;
   logic [dlpe_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [MAC_W-1:0]            mac_ff, mac_in;
   logic [IP_W-1:0]             rip_ff, rip_in;
   logic [CNT_W-1:0]            i_ff, i_in;
   logic                        ip_phase_ff, ip_phase_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            sel_ff, sel_in;
   logic                        vac_ff, vac_in;
   logic [IDX_W-1:0]            vsel_ff, vsel_in;
   logic                        owned_ff, owned_in;
   logic [dlpe_pkg::KIND_W-1:0] kind_ff, kind_in;

   // shared comparator: owner against client MAC, or stored IP against requested IP
   logic [MAC_W-1:0] cmp_a, cmp_b;
   logic             cmp_eq;
   assign cmp_a  = ip_phase_ff ? {{(MAC_W-IP_W){1'b0}}, ip_rd_ff} : owner_eff;
   assign cmp_b  = ip_phase_ff ? {{(MAC_W-IP_W){1'b0}}, rip_ff}   : mac_ff;
   assign cmp_eq = (cmp_a == cmp_b);

   logic [IDX_W-1:0] cur_idx;
   assign cur_idx = i_ff[IDX_W-1:0];

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_load;
   logic [dlpe_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [IP_W-1:0]             rsp_ip_ff, rsp_sub_ff, rsp_srv_ff, rsp_dns_ff;
   logic [LS_W-1:0]             rsp_lse_ff;

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      mac_in       = mac_ff;
      rip_in       = rip_ff;
      i_in         = i_ff;
      ip_phase_in  = ip_phase_ff;
      hit_in       = hit_ff;
      sel_in       = sel_ff;
      vac_in       = vac_ff;
      vsel_in      = vsel_ff;
      owned_in     = owned_ff;
      kind_in      = kind_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_idx;
      own_we       = 1'b0;
      own_wa       = sel_ff;
      own_wd       = '0;
      load_we      = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in      = req_bus.command;
               mac_in      = req_bus.client_mac;
               rip_in      = req_bus.requested_ip;
               i_in        = '0;
               ip_phase_in = 1'b0;
               hit_in      = 1'b0;
               vac_in      = 1'b0;
               kind_in     = dlpe_pkg::KIND_NONE;
               state_in    = ST_RESP;
               unique case (req_bus.command)
                  dlpe_pkg::CMD_DISCOVER: state_in = ST_RD;
                  dlpe_pkg::CMD_REQUEST: begin
                     if (req_bus.requested_present) state_in = ST_RD;
                  end
                  dlpe_pkg::CMD_LOAD: begin
                     load_we = (32'(req_bus.load_index) < POOL_ENTRIES);
                  end
                  default: ;
               endcase
            end
         end

         ST_RD: begin
            if (i_ff == n_len) begin
               state_in = ST_END;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CMP;
            end
         end

         ST_CMP: begin
            if (cmp_eq) begin
               hit_in   = 1'b1;
               sel_in   = cur_idx;
               owned_in = (owner_eff != '0);
               state_in = ST_END;
            end else begin
               // first vacant entry noted on the owner pass for discover fallback
               if (!ip_phase_ff && owner_eff == '0 && !vac_ff) begin
                  vac_in  = 1'b1;
                  vsel_in = cur_idx;
               end
               i_in     = CNT_W'(i_ff + 1'b1);
               state_in = ST_RD;
            end
         end

         ST_END: begin
            if (!ip_phase_ff) begin
               if (cmd_ff == dlpe_pkg::CMD_DISCOVER) begin
                  if (hit_ff) begin
                     kind_in  = dlpe_pkg::KIND_OFFER;
                     state_in = ST_LOOK;
                  end else if (vac_ff) begin
                     sel_in   = vsel_ff;
                     kind_in  = dlpe_pkg::KIND_OFFER;
                     state_in = ST_LOOK;
                  end else begin
                     state_in = ST_RESP;
                  end
               end else begin
                  // request: release the client's old entry, then scan by IP
                  if (hit_ff) begin
                     own_we = 1'b1;
                     own_wd = '0;
                  end
                  ip_phase_in = 1'b1;
                  i_in        = '0;
                  hit_in      = 1'b0;
                  state_in    = ST_RD;
               end
            end else begin
               if (hit_ff && !owned_ff) begin
                  own_we   = 1'b1;
                  own_wd   = mac_ff;
                  kind_in  = dlpe_pkg::KIND_ACK;
                  state_in = ST_LOOK;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_LOOK: begin
            rd_en    = 1'b1;
            rd_addr  = sel_ff;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         ip_phase_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         vac_ff       <= 1'b0;
         owned_ff     <= 1'b0;
         kind_ff      <= dlpe_pkg::KIND_NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         ip_phase_ff  <= ip_phase_in;
         hit_ff       <= hit_in;
         vac_ff       <= vac_in;
         owned_ff     <= owned_in;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      mac_ff  <= mac_in;
      rip_ff  <= rip_in;
      sel_ff  <= sel_in;
      vsel_ff <= vsel_in;
   end

   // result word; a no-reply word is all zero
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff <= kind_ff;
         if (kind_ff == dlpe_pkg::KIND_NONE) begin
            rsp_ip_ff  <= '0;
            rsp_sub_ff <= '0;
            rsp_lse_ff <= '0;
            rsp_srv_ff <= '0;
            rsp_dns_ff <= '0;
         end else begin
            rsp_ip_ff  <= (kind_ff == dlpe_pkg::KIND_ACK) ? rip_ff : ip_rd_ff;
            rsp_sub_ff <= sub_rd_ff;
            rsp_lse_ff <= lse_rd_ff;
            rsp_srv_ff <= server_ff;
            rsp_dns_ff <= dns_ff;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.reply_kind    = rsp_kind_ff;
   assign rsp_bus.your_ip       = rsp_ip_ff;
   assign rsp_bus.subnet_mask   = rsp_sub_ff;
   assign rsp_bus.lease_seconds = rsp_lse_ff;
   assign rsp_bus.server_id     = rsp_srv_ff;
   assign rsp_bus.dns_server    = rsp_dns_ff;

   // ---------------- assertions ----------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("engine took a second word while busy");

   a_no_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.reply_kind == dlpe_pkg::KIND_NONE) |->
      (rsp_bus.your_ip == '0 && rsp_bus.subnet_mask == '0 && rsp_bus.server_id == '0))
      else $error("no-reply word carries data");

   a_ack_records_owner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END && ip_phase_ff && hit_ff && !owned_ff) |-> own_we)
      else $error("acknowledged entry not claimed");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the DHCP lease pool engine: shadow pool, driver, monitor, stimulus.
module testbench;

   localparam int POOL_N      = 16;
   localparam int N_CLIENTS   = 24;   // more clients than entries, so the pool fills and drains
   localparam int N_ADDRS     = 20;   // pool addresses plus a few spare ones for reloads
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 80;   // longer than the slowest request scan

   // command 3 has no meaning; the engine must answer it with an empty reply
   localparam logic [dlpe_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [dlpe_pkg::CMD_W-1:0]   command;
      logic [dlpe_pkg::MAC_W-1:0]   client_mac;
      logic [dlpe_pkg::IP_W-1:0]    requested_ip;
      logic                         requested_present;
      logic [dlpe_pkg::LIDX_W-1:0]  load_index;
      logic [dlpe_pkg::IP_W-1:0]    load_ip;
      logic [dlpe_pkg::IP_W-1:0]    load_subnet;
      logic [dlpe_pkg::LEASE_W-1:0] load_lease;
   } req_word_type;

   typedef struct packed {
      logic [dlpe_pkg::KIND_W-1:0]  reply_kind;
      logic [dlpe_pkg::IP_W-1:0]    your_ip;
      logic [dlpe_pkg::IP_W-1:0]    subnet_mask;
      logic [dlpe_pkg::LEASE_W-1:0] lease_seconds;
      logic [dlpe_pkg::IP_W-1:0]    server_id;
      logic [dlpe_pkg::IP_W-1:0]    dns_server;
   } rsp_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [dlpe_pkg::CSR_AW-1:0] paddr;
   logic [dlpe_pkg::CSR_DW-1:0] pwdata;
   logic [dlpe_pkg::CSR_DW-1:0] prdata;
   logic                        pready;

   dlpe_req_if req_bus ();
   dlpe_rsp_if rsp_bus ();

   dhcp_lease_pool_engine #(
      .POOL_ENTRIES (POOL_N)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the pool and registers, updated as words are accepted
   // ---------------------------------------------------------------------
   logic [dlpe_pkg::MAC_W-1:0]   lease_owner [POOL_N];   // zero = vacant
   logic [dlpe_pkg::IP_W-1:0]    entry_ip    [POOL_N];
   logic [dlpe_pkg::IP_W-1:0]    entry_mask  [POOL_N];
   logic [dlpe_pkg::LEASE_W-1:0] entry_lease [POOL_N];
   logic [dlpe_pkg::EIU_W-1:0]   cfg_entries;
   logic [dlpe_pkg::IP_W-1:0]    cfg_server;
   logic [dlpe_pkg::IP_W-1:0]    cfg_dns;

   // stimulus pools
   logic [dlpe_pkg::MAC_W-1:0]   client_macs [N_CLIENTS];
   logic [dlpe_pkg::IP_W-1:0]    addr_set    [N_ADDRS];

   req_word_type pending_words   [$];   // waiting for the driver
   rsp_word_type awaited_replies [$];   // predicted, not yet seen on rsp_bus
   req_word_type on_wire;               // word currently presented on req_bus

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int words_queued   = 0;
   int words_accepted = 0;
   int replies_seen   = 0;
   int offers_seen    = 0;
   int acks_seen      = 0;
   int mismatches     = 0;
   int csr_writes     = 0;
   int cycle_count    = 0;

   function automatic rsp_word_type granted_reply(input logic [dlpe_pkg::KIND_W-1:0] kind,
                                                  input logic [dlpe_pkg::IP_W-1:0] ip,
                                                  input int idx);
      rsp_word_type r;
      r.reply_kind    = kind;
      r.your_ip       = ip;
      r.subnet_mask   = entry_mask[idx];
      r.lease_seconds = entry_lease[idx];
      r.server_id     = cfg_server;
      r.dns_server    = cfg_dns;
      return r;
   endfunction

   // Works out the reply to one accepted word and applies its effect on the pool.
   function automatic rsp_word_type predict_reply(input req_word_type w);
      rsp_word_type r;
      int           n;
      int           hit;
      r   = '0;
      hit = -1;
      // search lengths beyond the pool clamp to the pool size
      n   = (cfg_entries > POOL_N) ? POOL_N : int'(cfg_entries);
      case (w.command)
         dlpe_pkg::CMD_DISCOVER: begin
            // own entry first, else first vacant; nothing is reserved
            for (int i = 0; i < n; i++)
               if (hit < 0 && lease_owner[i] == w.client_mac) hit = i;
            for (int i = 0; i < n; i++)
               if (hit < 0 && lease_owner[i] == '0) hit = i;
            if (hit >= 0) r = granted_reply(dlpe_pkg::KIND_OFFER, entry_ip[hit], hit);
         end
         dlpe_pkg::CMD_REQUEST: begin
            if (w.requested_present) begin
               // release the old lease, even when the request is then refused
               for (int i = 0; i < n; i++)
                  if (hit < 0 && lease_owner[i] == w.client_mac) hit = i;
               if (hit >= 0) lease_owner[hit] = '0;
               hit = -1;
               for (int i = 0; i < n; i++)
                  if (hit < 0 && entry_ip[i] == w.requested_ip) hit = i;
               // only the first entry holding the address counts
               if (hit >= 0 && lease_owner[hit] == '0) begin
                  lease_owner[hit] = w.client_mac;
                  r = granted_reply(dlpe_pkg::KIND_ACK, w.requested_ip, hit);
               end
            end
         end
         dlpe_pkg::CMD_LOAD: begin
            // load_index is four bits wide, so it is always inside the pool
            entry_ip[w.load_index]    = w.load_ip;
            entry_mask[w.load_index]  = w.load_subnet;
            entry_lease[w.load_index] = w.load_lease;
         end
         default: ;   // unused command: no change, empty reply
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: takes words from pending_words, random gaps while valid is low
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      logic offer_next;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         offer_next = req_bus.valid && !req_bus.ready;   // word still waiting
         if (req_bus.valid && req_bus.ready) begin
            awaited_replies.push_back(predict_reply(on_wire));
            words_accepted++;
         end
         if (!offer_next && pending_words.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            on_wire                   = pending_words.pop_front();
            offer_next                = 1'b1;
            req_bus.command           <= on_wire.command;
            req_bus.client_mac        <= on_wire.client_mac;
            req_bus.requested_ip      <= on_wire.requested_ip;
            req_bus.requested_present <= on_wire.requested_present;
            req_bus.load_index        <= on_wire.load_index;
            req_bus.load_ip           <= on_wire.load_ip;
            req_bus.load_subnet       <= on_wire.load_subnet;
            req_bus.load_lease        <= on_wire.load_lease;
         end
         req_bus.valid <= offer_next;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compares each result word with the oldest prediction
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch_rsp
      rsp_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
               $error("result word with no command outstanding");
               mismatches++;
            end else begin
               want = awaited_replies.pop_front();
               if (want.reply_kind == dlpe_pkg::KIND_OFFER) offers_seen++;
               if (want.reply_kind == dlpe_pkg::KIND_ACK)   acks_seen++;
               check_field("reply_kind", 64'(want.reply_kind), 64'(rsp_bus.reply_kind));
               check_field("your_ip", 64'(want.your_ip), 64'(rsp_bus.your_ip));
               check_field("subnet_mask", 64'(want.subnet_mask), 64'(rsp_bus.subnet_mask));
               check_field("lease_seconds", 64'(want.lease_seconds),
                           64'(rsp_bus.lease_seconds));
               check_field("server_id", 64'(want.server_id), 64'(rsp_bus.server_id));
               check_field("dns_server", 64'(want.dns_server), 64'(rsp_bus.dns_server));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timed out after %0d cycles, %0d replies outstanding",
                cycle_count, awaited_replies.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Random content everywhere; callers then set the fields that matter.
   function automatic req_word_type word_of(input logic [dlpe_pkg::CMD_W-1:0] cmd);
      req_word_type w;
      logic [63:0]  r;
      r                   = {$urandom, $urandom};
      w.client_mac        = r[dlpe_pkg::MAC_W-1:0];
      r                   = {$urandom, $urandom};
      w.requested_ip      = r[dlpe_pkg::IP_W-1:0];
      w.requested_present = r[32];
      w.load_index        = r[36:33];
      w.load_ip           = $urandom;
      w.load_subnet       = $urandom;
      r                   = {$urandom, $urandom};
      w.load_lease        = r[dlpe_pkg::LEASE_W-1:0];
      w.command           = cmd;
      return w;
   endfunction

   function automatic logic [dlpe_pkg::MAC_W-1:0] pick_client();
      if ($urandom_range(99) < 3) return '0;
      return client_macs[$urandom_range(N_CLIENTS-1)];
   endfunction

   task automatic send(input req_word_type w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Block is idle once every queued word has been taken and answered.
   task automatic wait_idle();
      while (words_accepted != words_queued || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, register taken at the access edge.
   task automatic csr_write(input logic [1:0] idx, input logic [dlpe_pkg::CSR_DW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         dlpe_pkg::REG_ENTRIES_IN_USE: cfg_entries = value[dlpe_pkg::EIU_W-1:0];
         dlpe_pkg::REG_SERVER_ADDR:    cfg_server  = value;
         dlpe_pkg::REG_DNS_IP:         cfg_dns     = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic apply_settings(input logic [dlpe_pkg::CSR_DW-1:0] eiu,
                                 input logic [dlpe_pkg::CSR_DW-1:0] srv,
                                 input logic [dlpe_pkg::CSR_DW-1:0] dns);
      wait_idle();
      csr_write(dlpe_pkg::REG_ENTRIES_IN_USE, eiu);
      csr_write(dlpe_pkg::REG_SERVER_ADDR, srv);
      csr_write(dlpe_pkg::REG_DNS_IP, dns);
   endtask

   // Mostly client traffic against known pool addresses, with DHCP-like
   // discover/request pairs, occasional reloads and some noise.
   task automatic random_words(input int count);
      req_word_type w;
      int           sent;
      int           roll;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         if (roll < 38) begin
            w = word_of(dlpe_pkg::CMD_DISCOVER);
            if ($urandom_range(9) != 0) w.client_mac = pick_client();
            send(w);
            sent++;
            if ($urandom_range(1) == 1) begin
               // follow up with a request from the same client
               w = word_of(dlpe_pkg::CMD_REQUEST);
               w.client_mac        = pending_words[$].client_mac;
               w.requested_present = 1'b1;
               w.requested_ip      = addr_set[$urandom_range(N_ADDRS-1)];
               send(w);
               sent++;
            end
         end else if (roll < 78) begin
            w = word_of(dlpe_pkg::CMD_REQUEST);
            w.client_mac        = pick_client();
            w.requested_present = ($urandom_range(9) != 0);
            if ($urandom_range(99) < 85) w.requested_ip = addr_set[$urandom_range(N_ADDRS-1)];
            send(w);
            sent++;
         end else if (roll < 95) begin
            w = word_of(dlpe_pkg::CMD_LOAD);
            if ($urandom_range(99) < 85) w.load_ip = addr_set[$urandom_range(N_ADDRS-1)];
            send(w);
            sent++;
         end else begin
            send(word_of(CMD_UNUSED));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      req_word_type w;
      logic [63:0]  rnd;
      // known values on every input from time zero
      req_bus.valid             = 1'b0;
      req_bus.command           = dlpe_pkg::CMD_DISCOVER;
      req_bus.client_mac        = '0;
      req_bus.requested_ip      = '0;
      req_bus.requested_present = 1'b0;
      req_bus.load_index        = '0;
      req_bus.load_ip           = '0;
      req_bus.load_subnet       = '0;
      req_bus.load_lease        = '0;
      rsp_bus.ready             = 1'b0;
      psel                      = 1'b0;
      penable                   = 1'b0;
      pwrite                    = 1'b0;
      paddr                     = '0;
      pwdata                    = '0;
      on_wire                   = '0;

      // shadow state after reset: every owner vacant, registers zero
      for (int i = 0; i < POOL_N; i++) begin
         lease_owner[i] = '0;
         entry_ip[i]    = '0;
         entry_mask[i]  = '0;
         entry_lease[i] = '0;
      end
      cfg_entries = '0;
      cfg_server  = '0;
      cfg_dns     = '0;

      client_macs[0] = {dlpe_pkg::MAC_W{1'b1}};
      for (int i = 1; i < N_CLIENTS; i++) begin
         rnd            = {$urandom, $urandom};
         client_macs[i] = rnd[dlpe_pkg::MAC_W-1:0];
      end
      for (int i = 0; i < N_ADDRS; i++)   addr_set[i]    = $urandom;
      addr_set[0]  = '0;
      addr_set[15] = '1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: search length still zero, so nothing can match
      w = word_of(dlpe_pkg::CMD_DISCOVER);
      w.client_mac = client_macs[1];
      send(w);
      send(word_of(CMD_UNUSED));

      // fill the whole pool before any search reaches it; extremes in 0 and 15
      for (int i = 0; i < POOL_N; i++) begin
         w = word_of(dlpe_pkg::CMD_LOAD);
         w.load_index = i[dlpe_pkg::LIDX_W-1:0];
         w.load_ip    = addr_set[i];
         if (i == 0) begin
            w.load_subnet = '0;
            w.load_lease  = '0;
         end else if (i == POOL_N-1) begin
            w.load_subnet = '1;
            w.load_lease  = '1;
         end
         send(w);
      end

      apply_settings(POOL_N, 32'hFFFF_FFFF, 32'h0);
      // all-ones MAC takes entry 0, then sees it again as its own
      w = word_of(dlpe_pkg::CMD_DISCOVER);
      w.client_mac = client_macs[0];
      send(w);
      w = word_of(dlpe_pkg::CMD_REQUEST);
      w.client_mac = client_macs[0]; w.requested_ip = addr_set[0]; w.requested_present = 1'b1;
      send(w);
      w = word_of(dlpe_pkg::CMD_DISCOVER);
      w.client_mac = client_macs[0];
      send(w);
      // option missing: ignored
      w = word_of(dlpe_pkg::CMD_REQUEST);
      w.client_mac = client_macs[1]; w.requested_ip = addr_set[1]; w.requested_present = 1'b0;
      send(w);
      // address already leased to someone else: refused
      w = word_of(dlpe_pkg::CMD_REQUEST);
      w.client_mac = client_macs[1]; w.requested_ip = addr_set[0]; w.requested_present = 1'b1;
      send(w);
      // zero MAC: granted, yet the entry stays vacant
      w = word_of(dlpe_pkg::CMD_REQUEST);
      w.client_mac = '0; w.requested_ip = addr_set[15]; w.requested_present = 1'b1;
      send(w);
      // moving client frees entry 0 and takes entry 2
      w = word_of(dlpe_pkg::CMD_REQUEST);
      w.client_mac = client_macs[0]; w.requested_ip = addr_set[2]; w.requested_present = 1'b1;
      send(w);
      w = word_of(dlpe_pkg::CMD_DISCOVER);
      w.client_mac = '0;
      send(w);
      // address not in the pool
      w = word_of(dlpe_pkg::CMD_REQUEST);
      w.client_mac = client_macs[1]; w.requested_ip = addr_set[17]; w.requested_present = 1'b1;
      send(w);

      // one-entry pool: lease it, then a newcomer finds the pool full
      apply_settings(1, 32'h0, 32'hFFFF_FFFF);
      w = word_of(dlpe_pkg::CMD_REQUEST);
      w.client_mac = client_macs[1]; w.requested_ip = addr_set[0]; w.requested_present = 1'b1;
      send(w);
      w = word_of(dlpe_pkg::CMD_DISCOVER);
      w.client_mac = client_macs[2];
      send(w);

      // --- random part, four idling patterns, two settings each.
      // Each settings change waits for every reply, so the sender holds
      // off completely at least once per phase.
      apply_settings(POOL_N, $urandom, $urandom);
      random_words(115);
      apply_settings(31, 32'h0, 32'hFFFF_FFFF);   // clamps to the pool size
      random_words(115);

      wait_idle();
      send_idle_pct = 57;
      apply_settings(3, $urandom, $urandom);
      random_words(115);
      apply_settings(1, $urandom, $urandom);
      random_words(115);

      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 57;
      apply_settings(8, $urandom, $urandom);
      random_words(115);
      apply_settings(20, $urandom, $urandom);
      random_words(115);

      wait_idle();
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      apply_settings($urandom_range(POOL_N, 1), $urandom, $urandom);
      random_words(115);
      apply_settings(POOL_N, 32'hFFFF_FFFF, 32'h0);
      random_words(115);

      // drain, then give the engine time to show any stray word
      while (words_accepted != words_queued || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (awaited_replies.size() != 0) begin
         $error("%0d predicted replies never arrived", awaited_replies.size());
         mismatches++;
      end

      $display("Checked %0d result words for %0d command words: %0d offers, %0d acks.",
               replies_seen, words_accepted, offers_seen, acks_seen);
      $display("%0d register writes, search lengths from 0 to 31, four idling patterns.",
               csr_writes);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
